// ===== sv/debounced_matrix_key_rollover_macros.svh =====
// assertion helpers for the key rollover block
`ifndef DEBOUNCED_MATRIX_KEY_ROLLOVER_MACROS_SVH
`define DEBOUNCED_MATRIX_KEY_ROLLOVER_MACROS_SVH

// same-cycle implication
`define DMKR_ASSERT_IMP(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("dmkr assertion failed");

// next-cycle implication
`define DMKR_ASSERT_NXT(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("dmkr assertion failed");

`endif

// ===== sv/dmkr_pkg.sv =====
package dmkr_pkg;

  localparam int ROWS           = 12;
  localparam int COLUMNS        = 11;
  localparam int MAX_KEYS       = 6;
  localparam int DEPTH          = 3;

  localparam int ROW_W          = 4;
  localparam int COL_IN_W       = 11;
  localparam int KEY_W          = 8;
  localparam int COUNT_W        = 3;

  localparam int ENTRIES        = DEPTH * ROWS;
  localparam int ADDR_W         = $clog2(ENTRIES);
  localparam int SLOT_W         = 2;
  localparam int COL_CNT_W      = $clog2(COLUMNS);
  localparam int LIST_IDX_W     = $clog2(MAX_KEYS);
  localparam int NEW_CNT_W      = $clog2(MAX_KEYS + 1);
  localparam int MERGE_W        = $clog2(2 * MAX_KEYS);

  localparam int IN_TDATA_W     = 16;
  localparam int OUT_TDATA_W    = 56;

  localparam logic [ROW_W-1:0]     LAST_ROW  = ROW_W'(ROWS - 1);
  localparam logic [COUNT_W-1:0]   COUNT_MAX = COUNT_W'(MAX_KEYS);
  localparam logic [COL_IN_W-1:0]  COL_MASK  =
    (COLUMNS >= COL_IN_W) ? {COL_IN_W{1'b1}} : COL_IN_W'((1 << COLUMNS) - 1);

  typedef logic [KEY_W-1:0]    key_t;
  typedef logic [COL_IN_W-1:0] col_word_t;

  typedef struct packed {
    key_t [MAX_KEYS-1:0] keys;
    logic [COUNT_W-1:0]  count;
  } result_t;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    col_word_t         wr_data;
    logic [ADDR_W-1:0] rd_addr;
  } mem_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_FOLD,
    ST_WALK,
    ST_MERGE,
    ST_CHECK,
    ST_EMIT
  } engine_state_t;

  function automatic logic [ADDR_W-1:0] frame_addr(input logic [SLOT_W-1:0] slot,
                                                   input logic [ROW_W-1:0]  row);
    frame_addr = ADDR_W'(slot) * ADDR_W'(ROWS) + ADDR_W'(row);
  endfunction

endpackage

// ===== sv/dmkr_frame_store.sv =====
module dmkr_frame_store (
  input  logic                clk,
  input  logic                rst,
  input  dmkr_pkg::mem_req_t  req,
  output dmkr_pkg::col_word_t rd_data
);

  dmkr_pkg::col_word_t               mem [dmkr_pkg::ENTRIES];
  logic [dmkr_pkg::ENTRIES-1:0]      valid;
  dmkr_pkg::col_word_t               rd_word;
  logic                              rd_hit;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    rd_word <= mem[req.rd_addr];
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rd_hit <= 1'b0;
    end else begin
      if (req.wr_en) begin
        valid[req.wr_addr] <= 1'b1;
      end
      rd_hit <= valid[req.rd_addr];
    end
  end

  assign rd_data = rd_hit ? rd_word : '0;

endmodule

// ===== sv/dmkr_rollover_engine.sv =====
module dmkr_rollover_engine (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [dmkr_pkg::ROW_W-1:0]   in_row,
  input  dmkr_pkg::col_word_t          in_bits,
  output dmkr_pkg::mem_req_t           mem_req,
  input  dmkr_pkg::col_word_t          rd_data,
  output logic                         res_valid,
  input  logic                         res_ready,
  output dmkr_pkg::result_t            res
);

  dmkr_pkg::engine_state_t state, state_next;

  logic [dmkr_pkg::SLOT_W-1:0]     slot;
  logic [dmkr_pkg::ROW_W-1:0]      row_cnt;
  logic [dmkr_pkg::SLOT_W-1:0]     dep_cnt;
  logic [dmkr_pkg::COL_CNT_W-1:0]  col_cnt;
  dmkr_pkg::key_t                  pos;
  dmkr_pkg::col_word_t             acc;
  dmkr_pkg::col_word_t             stable;
  logic [dmkr_pkg::MAX_KEYS-1:0]   keep;
  dmkr_pkg::key_t                  new_list  [dmkr_pkg::MAX_KEYS];
  logic [dmkr_pkg::NEW_CNT_W-1:0]  new_cnt;
  logic [dmkr_pkg::MERGE_W-1:0]    merge_cnt;
  dmkr_pkg::key_t                  next_list [dmkr_pkg::MAX_KEYS];
  logic [dmkr_pkg::NEW_CNT_W-1:0]  next_total;
  dmkr_pkg::key_t                  held_list [dmkr_pkg::MAX_KEYS];
  logic [dmkr_pkg::NEW_CNT_W-1:0]  held_total;

  logic                            accept;
  logic                            frame_end;
  logic [dmkr_pkg::MAX_KEYS-1:0]   hit_vec;
  logic                            key_on;
  logic                            cand_valid;
  dmkr_pkg::key_t                  cand_key;
  logic [dmkr_pkg::MERGE_W-1:0]    new_idx;
  logic                            changed;

  assign accept    = in_valid && in_ready;
  assign frame_end = accept && (in_row == dmkr_pkg::LAST_ROW);
  assign key_on    = stable[col_cnt];
  assign new_idx   = merge_cnt - dmkr_pkg::MERGE_W'(dmkr_pkg::MAX_KEYS);

  // old list entries matching the key under the walk
  always_comb begin
    for (int i = 0; i < dmkr_pkg::MAX_KEYS; i++) begin
      hit_vec[i] = (dmkr_pkg::NEW_CNT_W'(i) < held_total) && (held_list[i] == pos);
    end
  end

  // merge step: kept old keys first, then new ones
  always_comb begin
    cand_valid = 1'b0;
    cand_key   = '0;
    if (merge_cnt < dmkr_pkg::MERGE_W'(dmkr_pkg::MAX_KEYS)) begin
      cand_valid = keep[merge_cnt[dmkr_pkg::LIST_IDX_W-1:0]];
      cand_key   = held_list[merge_cnt[dmkr_pkg::LIST_IDX_W-1:0]];
    end else begin
      cand_valid = (dmkr_pkg::NEW_CNT_W'(new_idx) < new_cnt);
      cand_key   = new_list[new_idx[dmkr_pkg::LIST_IDX_W-1:0]];
    end
    if (next_total >= dmkr_pkg::NEW_CNT_W'(dmkr_pkg::MAX_KEYS)) begin
      cand_valid = 1'b0;
    end
  end

  always_comb begin
    changed = (next_total != held_total);
    for (int i = 0; i < dmkr_pkg::MAX_KEYS; i++) begin
      if ((dmkr_pkg::NEW_CNT_W'(i) < next_total) && (next_list[i] != held_list[i])) begin
        changed = 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      dmkr_pkg::ST_IDLE: begin
        if (frame_end) state_next = dmkr_pkg::ST_LOAD;
      end
      dmkr_pkg::ST_LOAD: begin
        if (dep_cnt == dmkr_pkg::SLOT_W'(dmkr_pkg::DEPTH - 1)) state_next = dmkr_pkg::ST_FOLD;
      end
      dmkr_pkg::ST_FOLD: begin
        state_next = dmkr_pkg::ST_WALK;
      end
      dmkr_pkg::ST_WALK: begin
        if (col_cnt == dmkr_pkg::COL_CNT_W'(dmkr_pkg::COLUMNS - 1)) begin
          state_next = (row_cnt == dmkr_pkg::LAST_ROW) ? dmkr_pkg::ST_MERGE : dmkr_pkg::ST_LOAD;
        end
      end
      dmkr_pkg::ST_MERGE: begin
        if (merge_cnt == dmkr_pkg::MERGE_W'(2 * dmkr_pkg::MAX_KEYS - 1)) begin
          state_next = dmkr_pkg::ST_CHECK;
        end
      end
      dmkr_pkg::ST_CHECK: begin
        state_next = changed ? dmkr_pkg::ST_EMIT : dmkr_pkg::ST_IDLE;
      end
      dmkr_pkg::ST_EMIT: begin
        if (res_ready) state_next = dmkr_pkg::ST_IDLE;
      end
      default: state_next = dmkr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready        = 1'b0;
    res_valid       = 1'b0;
    mem_req.wr_en   = 1'b0;
    mem_req.wr_addr = dmkr_pkg::frame_addr(slot, in_row);
    mem_req.wr_data = in_bits & dmkr_pkg::COL_MASK;
    mem_req.rd_addr = dmkr_pkg::frame_addr(dep_cnt, row_cnt);
    unique case (state)
      dmkr_pkg::ST_IDLE: begin
        in_ready      = !rst;
        mem_req.wr_en = in_valid && !rst && (32'(in_row) < dmkr_pkg::ROWS);
      end
      dmkr_pkg::ST_EMIT: begin
        res_valid = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
    res.count = dmkr_pkg::COUNT_W'(held_total);
    for (int i = 0; i < dmkr_pkg::MAX_KEYS; i++) begin
      res.keys[i] = (dmkr_pkg::NEW_CNT_W'(i) < held_total) ? held_list[i] : '0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= dmkr_pkg::ST_IDLE;
      slot       <= '0;
      held_total <= '0;
      for (int i = 0; i < dmkr_pkg::MAX_KEYS; i++) held_list[i] <= '0;
    end else begin
      state <= state_next;
      if (frame_end) begin
        slot <= (slot == dmkr_pkg::SLOT_W'(dmkr_pkg::DEPTH - 1)) ? '0 : slot + 1'b1;
      end
      if (state == dmkr_pkg::ST_CHECK && changed) begin
        held_total <= next_total;
        for (int i = 0; i < dmkr_pkg::MAX_KEYS; i++) held_list[i] <= next_list[i];
      end
    end
  end

  // frame pass datapath
  always_ff @(posedge clk) begin
    unique case (state)
      dmkr_pkg::ST_IDLE: begin
        row_cnt    <= '0;
        dep_cnt    <= '0;
        col_cnt    <= '0;
        pos        <= '0;
        keep       <= '0;
        new_cnt    <= '0;
        merge_cnt  <= '0;
        next_total <= '0;
        for (int i = 0; i < dmkr_pkg::MAX_KEYS; i++) next_list[i] <= '0;
      end
      dmkr_pkg::ST_LOAD: begin
        dep_cnt <= (dep_cnt == dmkr_pkg::SLOT_W'(dmkr_pkg::DEPTH - 1)) ? '0 : dep_cnt + 1'b1;
        acc     <= (dep_cnt == '0) ? '1 : (acc & rd_data);
      end
      dmkr_pkg::ST_FOLD: begin
        stable  <= acc & rd_data;
        col_cnt <= '0;
      end
      dmkr_pkg::ST_WALK: begin
        if (key_on) begin
          keep <= keep | hit_vec;
          if (hit_vec == '0 && new_cnt < dmkr_pkg::NEW_CNT_W'(dmkr_pkg::MAX_KEYS)) begin
            new_list[new_cnt[dmkr_pkg::LIST_IDX_W-1:0]] <= pos;
            new_cnt <= new_cnt + 1'b1;
          end
        end
        pos <= pos + 1'b1;
        if (col_cnt == dmkr_pkg::COL_CNT_W'(dmkr_pkg::COLUMNS - 1)) begin
          col_cnt <= '0;
          row_cnt <= row_cnt + 1'b1;
        end else begin
          col_cnt <= col_cnt + 1'b1;
        end
      end
      dmkr_pkg::ST_MERGE: begin
        if (cand_valid) begin
          next_list[next_total[dmkr_pkg::LIST_IDX_W-1:0]] <= cand_key;
          next_total <= next_total + 1'b1;
        end
        merge_cnt <= merge_cnt + 1'b1;
      end
      default: begin
        merge_cnt <= '0;
      end
    endcase
  end

endmodule

// ===== sv/debounced_matrix_key_rollover.sv =====
// channel   dir  tdata fields (lowest bit up)
// s_axis    in   row_index[3:0], column_bits[14:4], zero pad to 16
// m_axis    out  held_count[2:0], slot0_key..slot5_key 8 bits each, zero pad to 56
//
// a row with an index below 12 is written to the frame store; unless it ends a frame, ready stays high
// the last row starts a frame pass: per row 3 frame-store reads, a fold and an
// 11-column walk, then a merge of the kept and new key lists, a compare and,
// if the list changed, the hand-over to the output register; ready returns after that
// the pass is set by the single read port of the frame store and the walk of one key a cycle
// reset is synchronous; frame-store valid bits clear at once, no clearing pass
// a stalled output holds one item; the pass waits at hand-over while it is full
`include "debounced_matrix_key_rollover_macros.svh"

module debounced_matrix_key_rollover (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // row_index[3:0], column_bits[14:4], zeros above
  input  logic [dmkr_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // held_count[2:0], slot0_key[10:3] .. slot5_key[50:43], zeros above
  output logic [dmkr_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

  localparam int OUT_PAD = dmkr_pkg::OUT_TDATA_W - $bits(dmkr_pkg::result_t);

  logic [dmkr_pkg::ROW_W-1:0] in_row;
  dmkr_pkg::col_word_t        in_bits;
  dmkr_pkg::mem_req_t         mem_req;
  dmkr_pkg::col_word_t        rd_data;
  logic                       res_valid;
  logic                       res_ready;
  dmkr_pkg::result_t          res;

  // output register
  logic                       out_valid;
  dmkr_pkg::result_t          out_data;

  // unpack the incoming row item
  assign in_row  = s_axis_tdata[dmkr_pkg::ROW_W-1:0];
  assign in_bits = s_axis_tdata[dmkr_pkg::ROW_W +: dmkr_pkg::COL_IN_W];

  // history of the last frames, one row word per entry
  dmkr_frame_store u_store (
    .clk     (clk),
    .rst     (rst),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  // frame pass: debounce fold, key walk, list rebuild
  dmkr_rollover_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_row    (in_row),
    .in_bits   (in_bits),
    .mem_req   (mem_req),
    .rd_data   (rd_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // take a new report when the register is empty or draining this cycle
  assign res_ready = !out_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{OUT_PAD{1'b0}}, out_data};

  // last row of a frame starts the pass, so the input side goes busy
  `DMKR_ASSERT_NXT(a_frame_end_busy, clk, rst, s_axis_tvalid && s_axis_tready && in_row == dmkr_pkg::LAST_ROW, !s_axis_tready)
  // a report handed over is shown on the output next cycle
  `DMKR_ASSERT_NXT(a_report_lands, clk, rst, res_valid && res_ready, m_axis_tvalid)
  // no report holds more keys than the list has room for
  `DMKR_ASSERT_IMP(a_count_bound, clk, rst, out_valid, out_data.count <= dmkr_pkg::COUNT_MAX)

endmodule
